### rtl/core/ffha_pkg.sv
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int FREE_SLOTS_DEF = 64;
  localparam logic [31:0] HDR_BYTES = 32'd8;
  localparam logic [24:0] MIN_BLOCK = 25'd16;
  localparam logic [31:0] HEAP_BASE_RST = 32'd1048576;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'd16777216;
  localparam logic [11:0] PAGE_MASK = 12'hFFF;

  // request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_PAGE = 2'd1;
  localparam logic [1:0] MODE_PHYS = 2'd2;
  localparam logic [1:0] MODE_FREE = 2'd3;

  // result status
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] request_size;
    logic [31:0] block_addr;
    logic [24:0] block_size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] user_addr;
    logic [31:0] header_addr;
    logic [24:0] recorded_size;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [24:0] size;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     is_last;
  } cell_ctl_t;

endpackage

### rtl/core/ffha_cell.sv
`timescale 1ns / 1ps
module ffha_cell (
  input  logic               clk,
  input  ffha_pkg::cell_ctl_t ctl,
  input  ffha_pkg::entry_t   prv,
  input  ffha_pkg::entry_t   nxt,
  input  ffha_pkg::entry_t   head,
  output ffha_pkg::entry_t   q
);
  import ffha_pkg::*;

  // one table slot: takes a neighbor's entry, takes the head when it is the last cell in a rotation, or holds
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_PUSH:   q <= prv;
      CELL_SHIFT:  q <= nxt;
      CELL_ROTATE: q <= ctl.is_last ? head : nxt;
      default:     q <= q;
    endcase
  end
endmodule

### rtl/core/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// request   in         start && !busy        in_item (mode, sizes, address)
// result    out        done, one cycle       result (addresses, size, status)
// config    in         cfg_valid && ready    cfg_index, cfg_data
//
// free, halted and page-aligned requests go from S_IDLE through S_PREP back to S_IDLE.
// allocate and physical requests search through S_PREP, S_SEARCH and then S_RESTORE or S_BUMP; the table is a
// row of cells rotated one slot per cycle past the head, so the walk and the
// re-ordering after removal together bring every stored entry past the head.
// synchronous reset clears control state; table contents are undefined.
// the receiver cannot stall: each result is shown for exactly one cycle.
module first_fit_heap_allocator #(
  parameter int FREE_SLOTS = ffha_pkg::FREE_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  ffha_pkg::in_item_t  in_item,
  output logic                done,
  output ffha_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import ffha_pkg::*;

  localparam int CW = $clog2(FREE_SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_PREP    = 5'b00010,
    S_SEARCH  = 5'b00100,
    S_RESTORE = 5'b01000,
    S_BUMP    = 5'b10000
  } state_t;

  state_t      state;
  in_item_t    item;
  logic [31:0] heap_base;
  logic [31:0] heap_limit;
  logic [31:0] bump_pointer;
  logic [31:0] heap_start;
  logic        heap_started;
  logic        halted;
  logic [CW-1:0] free_count;
  logic [CW-1:0] left;
  logic [CW-1:0] rot;
  logic [32:0] base;
  logic [24:0] need;
  logic        page_only;
  out_item_t   found_res;

  entry_t    cell_q [FREE_SLOTS];
  cell_ctl_t cell_ctl [FREE_SLOTS];
  cell_op_t  cell_op;
  entry_t    fresh;

  // derived request values
  logic [31:0] hdr;
  logic [32:0] base_rnd;
  logic [31:0] start_eff;
  logic [31:0] bump_eff;
  logic [24:0] req_rnd;
  logic [24:0] req_hdr;
  logic [33:0] pg_aligned;
  logic [34:0] pg_end;
  logic [32:0] phys_cur;
  logic [33:0] bump_end;
  logic        head_fits;
  logic        free_take;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  always_comb begin
    hdr = item.block_addr - HDR_BYTES;
    base_rnd = ({1'b0, heap_base} + 33'(PAGE_MASK)) & ~33'(PAGE_MASK);
    start_eff = heap_started ? heap_start : base_rnd[31:0];
    bump_eff = heap_started ? bump_pointer : base_rnd[31:0];
    req_rnd = (({1'b0, item.request_size} + 25'd3) & ~25'd3) + 25'(HDR_BYTES);
    req_hdr = {1'b0, item.request_size} + 25'(HDR_BYTES);
    pg_aligned = ({2'b0, bump_eff} + 34'(HDR_BYTES) + 34'(PAGE_MASK)) & ~34'(PAGE_MASK);
    pg_end = {1'b0, pg_aligned} + 35'(item.request_size);
    phys_cur = ({1'b0, bump_eff} + 33'(PAGE_MASK)) & ~33'(PAGE_MASK);
    bump_end = {1'b0, base} + 34'(need);
    head_fits = (cell_q[0].size >= need) && (!page_only || cell_q[0].addr[11:0] == 12'd0);
    free_take = (item.block_addr != 32'd0) && !(heap_started && hdr < heap_start)
                && (free_count != CW'(FREE_SLOTS));
    fresh.addr = hdr;
    fresh.size = item.block_size;
  end

  // shift control for the row of cells
  always_comb begin
    cell_op = CELL_HOLD;
    case (state)
      S_PREP:    if (!halted && item.mode == MODE_FREE && free_take) cell_op = CELL_PUSH;
      S_SEARCH:  if (left != '0) cell_op = head_fits ? CELL_SHIFT : CELL_ROTATE;
      S_RESTORE: if (rot != '0) cell_op = CELL_ROTATE;
      default:   cell_op = CELL_HOLD;
    endcase
    for (int k = 0; k < FREE_SLOTS; k++) begin
      cell_ctl[k].op = cell_op;
      cell_ctl[k].is_last = (free_count == CW'(k + 1));
    end
  end

  // free table: newest entry in cell 0
  for (genvar k = 0; k < FREE_SLOTS; k++) begin : g_cell
    ffha_cell u_cell (
      .clk  (clk),
      .ctl  (cell_ctl[k]),
      .prv  ((k == 0) ? fresh : cell_q[(k == 0) ? 0 : k - 1]),
      .nxt  (cell_q[(k == FREE_SLOTS - 1) ? k : k + 1]),
      .head (cell_q[0]),
      .q    (cell_q[k])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RST;
      heap_limit <= HEAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HEAP_BASE) heap_base <= cfg_data;
      if (cfg_index == CFG_HEAP_LIMIT) heap_limit <= cfg_data;
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      heap_started <= 1'b0;
      halted <= 1'b0;
      free_count <= '0;
      bump_pointer <= '0;
      heap_start <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            item <= in_item;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (halted) begin
            state <= S_IDLE;
            done <= 1'b1;
            result <= '{32'd0, 32'd0, 25'd0, ST_OOM};
          end else if (item.mode == MODE_FREE) begin
            state <= S_IDLE;
            done <= 1'b1;
            if (item.block_addr == 32'd0) begin
              result <= '{32'd0, 32'd0, 25'd0, ST_IGNORED};
            end else begin
              result.user_addr <= item.block_addr;
              result.header_addr <= hdr;
              result.recorded_size <= item.block_size;
              if (heap_started && hdr < heap_start) result.status <= ST_IGNORED;
              else if (free_count == CW'(FREE_SLOTS)) result.status <= ST_FULL;
              else begin
                result.status <= ST_OK;
                free_count <= free_count + CW'(1);
              end
            end
          end else begin
            heap_started <= 1'b1;
            heap_start <= start_eff;
            case (item.mode)
              MODE_PAGE: begin
                state <= S_IDLE;
                done <= 1'b1;
                if (pg_end >= {3'b0, heap_limit}) begin
                  halted <= 1'b1;
                  bump_pointer <= bump_eff;
                  result <= '{32'd0, 32'd0, 25'd0, ST_OOM};
                end else begin
                  bump_pointer <= pg_end[31:0];
                  result.user_addr <= pg_aligned[31:0];
                  result.header_addr <= 32'(pg_aligned - 34'(HDR_BYTES));
                  result.recorded_size <= req_hdr;
                  result.status <= ST_OK;
                end
              end
              MODE_PHYS: begin
                done <= 1'b0;
                bump_pointer <= phys_cur[32] ? bump_eff : phys_cur[31:0];
                base <= phys_cur;
                need <= (req_hdr < MIN_BLOCK) ? MIN_BLOCK : req_hdr;
                page_only <= 1'b1;
                left <= free_count;
                state <= S_SEARCH;
              end
              default: begin
                done <= 1'b0;
                bump_pointer <= bump_eff;
                base <= {1'b0, bump_eff};
                need <= (req_rnd < MIN_BLOCK) ? MIN_BLOCK : req_rnd;
                page_only <= 1'b0;
                left <= free_count;
                state <= S_SEARCH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          done <= 1'b0;
          if (left == '0) begin
            state <= S_BUMP;
          end else if (head_fits) begin
            found_res.user_addr <= cell_q[0].addr + HDR_BYTES;
            found_res.header_addr <= cell_q[0].addr;
            found_res.recorded_size <= need;
            found_res.status <= ST_OK;
            free_count <= free_count - CW'(1);
            rot <= left - CW'(1);
            state <= S_RESTORE;
          end else begin
            left <= left - CW'(1);
          end
        end
        S_RESTORE: begin
          if (rot == '0) begin
            done <= 1'b1;
            result <= found_res;
            state <= S_IDLE;
          end else begin
            done <= 1'b0;
            rot <= rot - CW'(1);
          end
        end
        S_BUMP: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (bump_end >= {2'b0, heap_limit}) begin
            halted <= 1'b1;
            result <= '{32'd0, 32'd0, 25'd0, ST_OOM};
          end else begin
            bump_pointer <= bump_end[31:0];
            result.user_addr <= 32'(base + 33'(HDR_BYTES));
            result.header_addr <= base[31:0];
            result.recorded_size <= need;
            result.status <= ST_OK;
          end
        end
        default: begin
          done <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised after accept");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(FREE_SLOTS)) else $error("free count overflow");
  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt cleared");
  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    done && $past(halted) |-> result.status == ST_OOM) else $error("halted but ok");
`endif
endmodule

### verif/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int SLOTS = 64;

  typedef struct {
    bit          is_cfg;
    logic        idx;
    logic [31:0] data;
    in_item_t    item;
  } job_t;

  typedef struct {
    out_item_t res;
    logic [1:0] mode;
  } predicted_t;

  typedef struct {
    logic [31:0] addr;
    logic [24:0] size;
  } block_t;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      done;
  out_item_t result;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_index;
  logic [31:0] cfg_data;

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // allocator shadow state
  logic [31:0] sh_base, sh_limit, sh_bump, sh_heap_start;
  bit          sh_started, sh_halted;
  logic [31:0] sh_faddr[SLOTS];
  logic [24:0] sh_fsize[SLOTS];
  int          sh_fcount;

  job_t       pending_jobs[$];
  predicted_t expected_results[$];
  block_t     live_blocks[$];
  int         gap_left;
  bit         no_gaps;
  int         mismatches;
  int         results_seen;
  int         halts_seen;
  int         frees_seen;

  function automatic logic [63:0] page_up(logic [63:0] a);
    return (a + 64'd4095) & ~64'hFFF;
  endfunction

  function automatic out_item_t pack_res(logic [63:0] ua, logic [63:0] ha,
                                         logic [63:0] sz, logic [1:0] st);
    out_item_t r;
    r.user_addr = ua[31:0];
    r.header_addr = ha[31:0];
    r.recorded_size = sz[24:0];
    r.status = st;
    return r;
  endfunction

  // newest-first search, -1 when nothing fits
  function automatic int find_fit(logic [31:0] need, bit page_only);
    for (int i = sh_fcount - 1; i >= 0; i--) begin
      if ({7'd0, sh_fsize[i]} >= need && (!page_only || sh_faddr[i][11:0] == 12'd0))
        return i;
    end
    return -1;
  endfunction

  function automatic out_item_t take_slot(int k, logic [31:0] total);
    logic [31:0] a;
    a = sh_faddr[k];
    for (int i = k; i < sh_fcount - 1; i++) begin
      sh_faddr[i] = sh_faddr[i + 1];
      sh_fsize[i] = sh_fsize[i + 1];
    end
    sh_fcount--;
    return pack_res({32'd0, a} + 64'd8, {32'd0, a}, {32'd0, total}, ST_OK);
  endfunction

  function automatic out_item_t bump_take(logic [63:0] base, logic [31:0] total);
    if (base + {32'd0, total} >= {32'd0, sh_limit}) begin
      sh_halted = 1;
      return pack_res(0, 0, 0, ST_OOM);
    end
    sh_bump = base[31:0] + total;
    return pack_res(base + 64'd8, base, {32'd0, total}, ST_OK);
  endfunction

  function automatic out_item_t predict_alloc(in_item_t it);
    logic [31:0] hdr, total;
    logic [63:0] cur, aligned, span;
    int k;
    if (sh_halted) return pack_res(0, 0, 0, ST_OOM);
    if (it.mode == MODE_FREE) begin
      if (it.block_addr == 32'd0) return pack_res(0, 0, 0, ST_IGNORED);
      hdr = it.block_addr - 32'd8;
      if (sh_started && hdr < sh_heap_start)
        return pack_res({32'd0, it.block_addr}, {32'd0, hdr}, {39'd0, it.block_size}, ST_IGNORED);
      if (sh_fcount >= SLOTS)
        return pack_res({32'd0, it.block_addr}, {32'd0, hdr}, {39'd0, it.block_size}, ST_FULL);
      sh_faddr[sh_fcount] = hdr;
      sh_fsize[sh_fcount] = it.block_size;
      sh_fcount++;
      return pack_res({32'd0, it.block_addr}, {32'd0, hdr}, {39'd0, it.block_size}, ST_OK);
    end
    // first use latches the rounded base
    if (!sh_started) begin
      cur = page_up({32'd0, sh_base});
      sh_heap_start = cur[31:0];
      sh_bump = cur[31:0];
      sh_started = 1;
    end
    case (it.mode)
      MODE_ALLOC: begin
        total = (({8'd0, it.request_size} + 32'd3) & ~32'd3) + 32'd8;
        if (total < 32'd16) total = 32'd16;
        k = find_fit(total, 0);
        if (k >= 0) return take_slot(k, total);
        return bump_take({32'd0, sh_bump}, total);
      end
      MODE_PAGE: begin
        cur = {32'd0, sh_bump};
        aligned = page_up(cur + 64'd8);
        span = aligned - cur + {40'd0, it.request_size};
        if (cur + span >= {32'd0, sh_limit}) begin
          sh_halted = 1;
          return pack_res(0, 0, 0, ST_OOM);
        end
        sh_bump = cur[31:0] + span[31:0];
        return pack_res(aligned, aligned - 64'd8, {40'd0, it.request_size} + 64'd8, ST_OK);
      end
      default: begin
        cur = page_up({32'd0, sh_bump});
        if (cur[63:32] == 32'd0) sh_bump = cur[31:0];
        total = {8'd0, it.request_size} + 32'd8;
        if (total < 32'd16) total = 32'd16;
        k = find_fit(total, 1);
        if (k >= 0) return take_slot(k, total);
        return bump_take(cur, total);
      end
    endcase
  endfunction

  // clock and reset
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
  end

  // driver
  always @(posedge clk) begin
    logic fire, cfg_fire;
    job_t j;
    predicted_t p;
    fire = start && !busy;
    cfg_fire = cfg_valid && cfg_ready;
    if (rst) begin
      start <= 0;
      cfg_valid <= 0;
      gap_left <= 0;
    end else begin
      if (cfg_fire) begin
        if (cfg_index == CFG_HEAP_BASE) sh_base = cfg_data;
        else sh_limit = cfg_data;
      end
      if (fire) begin
        p.mode = in_item.mode;
        p.res = predict_alloc(in_item);
        expected_results.push_back(p);
      end
      if ((start && !fire) || (cfg_valid && !cfg_fire)) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
        cfg_valid <= 0;
      end else if (pending_jobs.size() > 0 && pending_jobs[0].is_cfg) begin
        start <= 0;
        // register writes only once the block is idle
        if (!fire && expected_results.size() == 0) begin
          j = pending_jobs.pop_front();
          cfg_valid <= 1;
          cfg_index <= j.idx;
          cfg_data <= j.data;
        end else begin
          cfg_valid <= 0;
        end
      end else if (pending_jobs.size() > 0) begin
        j = pending_jobs.pop_front();
        start <= 1;
        cfg_valid <= 0;
        in_item <= j.item;
        if (!no_gaps) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap_left <= 0;
            6, 7, 8: gap_left <= $urandom_range(1, 3);
            default: gap_left <= $urandom_range(10, 40);
          endcase
        end
      end else begin
        start <= 0;
        cfg_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    predicted_t p;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        p = expected_results.pop_front();
        if (result.user_addr !== p.res.user_addr ||
            result.header_addr !== p.res.header_addr ||
            result.recorded_size !== p.res.recorded_size ||
            result.status !== p.res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch mode %0d: expected %h %h %h %0d, got %h %h %h %0d",
                     p.mode, p.res.user_addr, p.res.header_addr, p.res.recorded_size,
                     p.res.status, result.user_addr, result.header_addr,
                     result.recorded_size, result.status);
        end
        if (p.res.status == ST_OOM) halts_seen++;
        if (p.mode == MODE_FREE && p.res.status == ST_OK) frees_seen++;
        // remember live blocks so later frees return real ones
        if (p.mode != MODE_FREE && p.res.status == ST_OK)
          live_blocks.push_back('{p.res.user_addr, p.res.recorded_size});
      end
    end
  end

  task automatic add_req(logic [1:0] m, logic [23:0] req, logic [31:0] addr,
                         logic [24:0] sz);
    job_t j;
    j.is_cfg = 0;
    j.item.mode = m;
    j.item.request_size = req;
    j.item.block_addr = addr;
    j.item.block_size = sz;
    pending_jobs.push_back(j);
  endtask

  task automatic add_cfg(logic idx, logic [31:0] val);
    job_t j;
    j.is_cfg = 1;
    j.idx = idx;
    j.data = val;
    j.item = '0;
    pending_jobs.push_back(j);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_jobs.size() > 0 || expected_results.size() > 0 || start || cfg_valid);
  endtask

  // one chunk of mostly well-formed traffic
  task automatic random_chunk(int n);
    int sel, k;
    block_t b;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        if ($urandom_range(0, 9) < 8)
          add_req(MODE_ALLOC, 24'($urandom_range(0, 300)), $urandom, 25'($urandom));
        else
          add_req(MODE_ALLOC, 24'($urandom_range(0, 20000)), $urandom, 25'($urandom));
      end else if (sel < 55) begin
        add_req(MODE_PAGE, 24'($urandom_range(0, 5000)), $urandom, 25'($urandom));
      end else if (sel < 65) begin
        add_req(MODE_PHYS, 24'($urandom_range(0, 5000)), $urandom, 25'($urandom));
      end else if (sel < 93 && live_blocks.size() > 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        b = live_blocks[k];
        live_blocks.delete(k);
        add_req(MODE_FREE, 24'($urandom), b.addr, b.size);
      end else begin
        add_req(MODE_FREE, 24'($urandom), ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                25'($urandom_range(0, 16777224)));
      end
    end
  endtask

  initial begin
    start = 0;
    cfg_valid = 0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = '0;
    in_item = '0;
    gap_left = 0;
    no_gaps = 0;
    mismatches = 0;
    results_seen = 0;
    halts_seen = 0;
    frees_seen = 0;
    sh_base = HEAP_BASE_RST;
    sh_limit = HEAP_LIMIT_RST;
    sh_bump = '0;
    sh_heap_start = '0;
    sh_started = 0;
    sh_halted = 0;
    sh_fcount = 0;
    @(negedge rst);

    add_cfg(CFG_HEAP_BASE, 32'h0010_0123);
    add_cfg(CFG_HEAP_LIMIT, 32'h0400_0000);

    // directed: edges of fields, every mode, free corner cases
    add_req(MODE_FREE, 24'd0, 32'd0, 25'd0);
    add_req(MODE_FREE, 24'd0, 32'd4, 25'd16);
    add_req(MODE_FREE, 24'hFFFFFF, 32'h0020_1008, 25'd16777224);
    add_req(MODE_ALLOC, 24'd0, 32'hFFFF_FFFF, 25'h1FF_FFFF);
    add_req(MODE_ALLOC, 24'd1, 32'd0, 25'd0);
    add_req(MODE_ALLOC, 24'd13, 32'd0, 25'd0);
    add_req(MODE_ALLOC, 24'd4096, 32'd0, 25'd0);
    add_req(MODE_PAGE, 24'd0, 32'd0, 25'd0);
    add_req(MODE_PAGE, 24'd100, 32'd0, 25'd0);
    add_req(MODE_PHYS, 24'd0, 32'd0, 25'd0);
    add_req(MODE_PHYS, 24'd5, 32'd0, 25'd0);
    add_req(MODE_FREE, 24'd0, 32'h0000_0100, 25'd32);
    add_req(MODE_FREE, 24'd0, 32'h0010_1008, 25'd4200);
    add_req(MODE_FREE, 24'd0, 32'h0011_0008, 25'd64);
    add_req(MODE_PHYS, 24'd50, 32'd0, 25'd0);
    add_req(MODE_ALLOC, 24'd40, 32'd0, 25'd0);
    add_req(MODE_ALLOC, 24'd2000, 32'd0, 25'd0);
    add_req(MODE_PAGE, 24'hFFFFFF, 32'd0, 25'd0);
    add_req(MODE_ALLOC, 24'hFF_FFFF, 32'd0, 25'd0);
    drain();

    for (int c = 0; c < 8; c++) begin
      no_gaps = (c % 3 == 2);
      random_chunk(50);
      drain();
    end

    // flood the free table until it overflows
    for (int i = 0; i < 70; i++)
      add_req(MODE_FREE, 24'd0, 32'h0200_0008 + i * 32'h1000,
              25'($urandom_range(16, 9000)));
    random_chunk(30);
    drain();

    // base write has no effect after first use
    add_cfg(CFG_HEAP_BASE, 32'hFFFF_F001);
    add_cfg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    for (int c = 0; c < 12; c++) begin
      no_gaps = (c % 4 == 1);
      random_chunk(50);
      drain();
    end

    // limit at zero: the next bump halts the block
    no_gaps = 0;
    add_cfg(CFG_HEAP_LIMIT, 32'h0000_0000);
    add_req(MODE_PAGE, 24'd8, 32'd0, 25'd0);
    random_chunk(10);
    drain();
    repeat (100) @(posedge clk);

    if (expected_results.size() > 0) mismatches += expected_results.size();
    $display("%0d results checked, %0d frees stored, %0d out-of-memory results,", results_seen,
             frees_seen, halts_seen);
    $display("across three limit settings, a table overflow and the halted state");
    if (mismatches == 0) begin
      $display("first_fit_heap_allocator regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("first_fit_heap_allocator regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("first_fit_heap_allocator regression: fail");
    $finish;
  end

endmodule
